// ----- design/lnq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the lattice neighbor query block.
// Used by every module of the block; depends on nothing.
package lnq_pkg;

    localparam int MAX_EXTENT = 1024;
    localparam int EXT_W      = 11;
    localparam int SITE_W     = 20;
    localparam int POS_W      = $clog2(MAX_EXTENT);
    localparam int TOT_W      = 2 * EXT_W;
    localparam int NBR_MAX    = 4;
    localparam int NBR_IW     = $clog2(NBR_MAX);
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        CFG_IS_CHAIN = 2'd0,
        CFG_EXTENT_X = 2'd1,
        CFG_EXTENT_Y = 2'd2,
        CFG_WRAP     = 2'd3
    } t_cfg_reg;

    localparam logic OP_LIST = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_CONFIG = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [SITE_W-1:0] site_a;
        logic [SITE_W-1:0] site_b;
    } t_cmd;

    typedef struct packed {
        logic [SITE_W-1:0] neighbor_site;
        logic              neighbor_present;
        logic              is_adjacent;
        logic [1:0]        status;
        logic              last;
    } t_result;

    typedef struct packed {
        logic              is_chain;
        logic [EXT_W-1:0]  extent_x;
        logic [EXT_W-1:0]  extent_y;
        logic              wrap;
        logic [TOT_W-1:0]  total;
        logic [SITE_W-1:0] top_off;
        logic              ok;
    } t_lat_cfg;

    typedef struct packed {
        logic              opcode;
        logic [SITE_W-1:0] site_a;
        logic [SITE_W-1:0] site_b;
        logic [1:0]        status;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
    } t_work;

endpackage

// ----- design/lattice_neighbor_query.sv -----
`timescale 1ns / 1ps
// Top level of the lattice neighbor query block: configuration registers and
// the front end, work queue and back end. Depends on lnq_pkg and submodules.
//
// Usage: configure through the write channel (i_cfg_valid, o_cfg_ready,
// i_cfg_index, i_cfg_data), index 0 chain select, 1 extent x, 2 extent y,
// 3 periodic edges. o_cfg_ready is always high. The user must make writes
// only while idle; the block does not enforce this. A command beat (i_cmd) is
// taken at a clock edge with start high and busy low. busy rises for one cycle
// after a configuration write while the site count is recomputed, and while
// the work queue and divider hold 16 items. Each command gives one to four
// result beats on o_result, each valid for a single cycle with o_result_valid;
// the last beat of a command has last set. A command passes through the
// eleven-stage front pipeline with its ten-step column and row divider, the
// work queue and the back end. Throughput: one command per cycle into the
// front end while busy is low; the back end emits one result per cycle, one
// to four results for each command.
// Reset clears the configuration to a 4 by 4 open square lattice and drops
// all items in flight. The receiver cannot stall results.
module lattice_neighbor_query (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  lnq_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [lnq_pkg::EXT_W-1:0] i_cfg_data,
    output logic                      o_result_valid,
    output lnq_pkg::t_result          o_result
);

    logic                       r_is_chain;
    logic [lnq_pkg::EXT_W-1:0]  r_extent_x;
    logic [lnq_pkg::EXT_W-1:0]  r_extent_y;
    logic                       r_wrap;
    logic [lnq_pkg::TOT_W-1:0]  r_total;
    logic [lnq_pkg::SITE_W-1:0] r_top_off;
    logic                       r_ok;
    logic                       r_cfg_hold;
    logic [lnq_pkg::TOT_W-1:0]  n_total;
    logic [lnq_pkg::EXT_W-1:0]  lim;
    logic                       n_ok;
    logic                       cfg_wr;
    logic                       accept;
    logic                       full;
    logic                       push;
    logic                       pop;
    logic                       empty;
    lnq_pkg::t_work             work;
    lnq_pkg::t_work             head;
    lnq_pkg::t_lat_cfg          cfg;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_chain <= 1'b0;
            r_extent_x <= lnq_pkg::EXT_W'(4);
            r_extent_y <= lnq_pkg::EXT_W'(4);
            r_wrap     <= 1'b0;
            r_cfg_hold <= 1'b1;
        end else begin
            r_cfg_hold <= cfg_wr;
            if (cfg_wr) begin
                unique case (lnq_pkg::t_cfg_reg'(i_cfg_index))
                    lnq_pkg::CFG_IS_CHAIN: r_is_chain <= i_cfg_data[0];
                    lnq_pkg::CFG_EXTENT_X: r_extent_x <= i_cfg_data;
                    lnq_pkg::CFG_EXTENT_Y: r_extent_y <= i_cfg_data;
                    lnq_pkg::CFG_WRAP:     r_wrap     <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        lim     = r_wrap ? lnq_pkg::EXT_W'(3) : lnq_pkg::EXT_W'(1);
        n_total = r_is_chain ? lnq_pkg::TOT_W'(r_extent_x) : r_extent_x * r_extent_y;
        n_ok    = (r_extent_x >= lim) &&
                  (r_extent_x <= lnq_pkg::EXT_W'(lnq_pkg::MAX_EXTENT)) &&
                  (r_is_chain ||
                   ((r_extent_y >= lim) &&
                    (r_extent_y <= lnq_pkg::EXT_W'(lnq_pkg::MAX_EXTENT))));
    end

    always_ff @(posedge i_clk) begin
        r_total   <= n_total;
        r_top_off <= lnq_pkg::SITE_W'(n_total - lnq_pkg::TOT_W'(r_extent_x));
        r_ok      <= n_ok;
    end

    always_comb begin
        cfg.is_chain = r_is_chain;
        cfg.extent_x = r_extent_x;
        cfg.extent_y = r_extent_y;
        cfg.wrap     = r_wrap;
        cfg.total    = r_total;
        cfg.top_off  = r_top_off;
        cfg.ok       = r_ok;
    end

    assign busy   = full || r_cfg_hold;
    assign accept = start && !busy;

    lnq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_cmd   (i_cmd),
        .i_cfg   (cfg),
        .i_pop   (pop),
        .o_full  (full),
        .o_push  (push),
        .o_work  (work)
    );

    lnq_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    lnq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_empty        (empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

// ----- design/lnq_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts commands, checks configuration and range, and splits
// the site into column and row in a pipelined divider. Depends on lnq_pkg.
module lnq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  lnq_pkg::t_cmd     i_cmd,
    input  lnq_pkg::t_lat_cfg i_cfg,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_push,
    output lnq_pkg::t_work    o_work
);

    typedef struct packed {
        logic                       valid;
        logic                       opcode;
        logic [lnq_pkg::SITE_W-1:0] site_a;
        logic [lnq_pkg::SITE_W-1:0] site_b;
        logic [1:0]                 status;
        logic [lnq_pkg::SITE_W-1:0] rem;
        logic [lnq_pkg::POS_W-1:0]  quo;
    } t_div_stage;

    t_div_stage r_st [lnq_pkg::POS_W+1];
    t_div_stage n_st [lnq_pkg::POS_W+1];
    logic [lnq_pkg::SITE_W:0]  dv [lnq_pkg::POS_W];
    logic [lnq_pkg::FIFO_AW:0] r_credit;
    logic [lnq_pkg::FIFO_AW:0] n_credit;
    logic [1:0]                status;

    always_comb begin
        if (!i_cfg.ok) begin
            status = lnq_pkg::ST_CONFIG;
        end else if ((lnq_pkg::TOT_W'(i_cmd.site_a) >= i_cfg.total) ||
                     ((i_cmd.opcode == lnq_pkg::OP_TEST) &&
                      (lnq_pkg::TOT_W'(i_cmd.site_b) >= i_cfg.total))) begin
            status = lnq_pkg::ST_RANGE;
        end else begin
            status = lnq_pkg::ST_OK;
        end
    end

    always_comb begin
        n_st[0].valid  = i_accept;
        n_st[0].opcode = i_cmd.opcode;
        n_st[0].site_a = i_cmd.site_a;
        n_st[0].site_b = i_cmd.site_b;
        n_st[0].status = status;
        n_st[0].rem    = i_cmd.site_a;
        n_st[0].quo    = '0;
        for (int i = 0; i < lnq_pkg::POS_W; i++) begin
            dv[i]     = (lnq_pkg::SITE_W+1)'(i_cfg.extent_x) << (lnq_pkg::POS_W - 1 - i);
            n_st[i+1] = r_st[i];
            if ({1'b0, r_st[i].rem} >= dv[i]) begin
                n_st[i+1].rem = lnq_pkg::SITE_W'({1'b0, r_st[i].rem} - dv[i]);
                n_st[i+1].quo[lnq_pkg::POS_W-1-i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= lnq_pkg::POS_W; i++) begin
            if (!i_rst_n) begin
                r_st[i] <= '0;
            end else begin
                r_st[i] <= n_st[i];
            end
        end
    end

    always_comb begin
        n_credit = r_credit;
        if (i_accept && !i_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!i_accept && i_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    assign o_full        = (r_credit == (lnq_pkg::FIFO_AW+1)'(lnq_pkg::FIFO_DEPTH));
    assign o_push        = r_st[lnq_pkg::POS_W].valid;
    assign o_work.opcode = r_st[lnq_pkg::POS_W].opcode;
    assign o_work.site_a = r_st[lnq_pkg::POS_W].site_a;
    assign o_work.site_b = r_st[lnq_pkg::POS_W].site_b;
    assign o_work.status = r_st[lnq_pkg::POS_W].status;
    assign o_work.col    = r_st[lnq_pkg::POS_W].rem[lnq_pkg::POS_W-1:0];
    assign o_work.row    = r_st[lnq_pkg::POS_W].quo;

endmodule

// ----- design/lnq_fifo.sv -----
`timescale 1ns / 1ps
// Work queue between the front end and the back end.
// Depends on lnq_pkg for the entry type and depth.
module lnq_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lnq_pkg::t_work i_work,
    input  logic           i_pop,
    output logic           o_empty,
    output lnq_pkg::t_work o_head
);

    lnq_pkg::t_work              r_mem [lnq_pkg::FIFO_DEPTH];
    logic [lnq_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [lnq_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [lnq_pkg::FIFO_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ----- design/lnq_back.sv -----
`timescale 1ns / 1ps
// Back end: forms the neighbor candidates, sorts them in a three-level
// network, and emits one result per cycle. Depends on lnq_pkg.
module lnq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lnq_pkg::t_lat_cfg i_cfg,
    input  logic              i_empty,
    input  lnq_pkg::t_work    i_head,
    output logic              o_pop,
    output logic              o_result_valid,
    output lnq_pkg::t_result  o_result
);

    typedef struct packed {
        logic                                             valid;
        logic                                             opcode;
        logic [lnq_pkg::SITE_W-1:0]                       site_b;
        logic [1:0]                                       status;
        logic                                             adj;
        logic [lnq_pkg::NBR_MAX-1:0][lnq_pkg::SITE_W:0]   key;
    } t_bstage;

    logic                       adv;
    logic                       r_s1_valid;
    lnq_pkg::t_work             r_s1;
    t_bstage                    r_s2, r_s3, r_s4, r_s5;
    t_bstage                    n_s2, n_s3, n_s4, n_s5;
    logic [lnq_pkg::SITE_W-1:0] s;
    logic [lnq_pkg::EXT_W-1:0]  col_nx, row_nx;
    logic [lnq_pkg::SITE_W-1:0] w;

    logic                       r_em_valid;
    logic [lnq_pkg::NBR_IW-1:0] r_em_idx, r_em_last;
    lnq_pkg::t_result           r_em_res [lnq_pkg::NBR_MAX];
    lnq_pkg::t_result           n_em_res [lnq_pkg::NBR_MAX];
    logic [lnq_pkg::NBR_IW-1:0] n_em_last;
    logic [lnq_pkg::NBR_IW:0]   cnt;
    logic                       r_out_valid;
    lnq_pkg::t_result           r_out;

    assign adv   = !r_em_valid || (r_em_idx == r_em_last);
    assign o_pop = adv && !i_empty;

    // Candidate neighbors; an absent one gets its top key bit set.
    always_comb begin
        s      = r_s1.site_a;
        w      = lnq_pkg::SITE_W'(i_cfg.extent_x);
        col_nx = lnq_pkg::EXT_W'(r_s1.col) + 1'b1;
        row_nx = lnq_pkg::EXT_W'(r_s1.row) + 1'b1;
        n_s2.valid  = r_s1_valid;
        n_s2.opcode = r_s1.opcode;
        n_s2.site_b = r_s1.site_b;
        n_s2.status = r_s1.status;
        n_s2.adj    = 1'b0;
        n_s2.key    = {lnq_pkg::NBR_MAX{1'b1, {lnq_pkg::SITE_W{1'b0}}}};
        if (r_s1.col != '0) begin
            n_s2.key[0] = {1'b0, s - 1'b1};
        end else if (i_cfg.wrap) begin
            n_s2.key[0] = {1'b0, s + w - 1'b1};
        end
        if (col_nx < i_cfg.extent_x) begin
            n_s2.key[1] = {1'b0, s + 1'b1};
        end else if (i_cfg.wrap) begin
            n_s2.key[1] = {1'b0, s - (w - 1'b1)};
        end
        if (!i_cfg.is_chain) begin
            if (r_s1.row != '0) begin
                n_s2.key[2] = {1'b0, s - w};
            end else if (i_cfg.wrap) begin
                n_s2.key[2] = {1'b0, s + i_cfg.top_off};
            end
            if (row_nx < i_cfg.extent_y) begin
                n_s2.key[3] = {1'b0, s + w};
            end else if (i_cfg.wrap) begin
                n_s2.key[3] = {1'b0, lnq_pkg::SITE_W'(r_s1.col)};
            end
        end
    end

    always_comb begin
        n_s3     = r_s2;
        n_s3.adj = 1'b0;
        for (int k = 0; k < lnq_pkg::NBR_MAX; k++) begin
            if (!r_s2.key[k][lnq_pkg::SITE_W] &&
                (r_s2.key[k][lnq_pkg::SITE_W-1:0] == r_s2.site_b)) begin
                n_s3.adj = 1'b1;
            end
        end
        if (r_s2.key[0] > r_s2.key[1]) begin
            n_s3.key[0] = r_s2.key[1];
            n_s3.key[1] = r_s2.key[0];
        end
        if (r_s2.key[2] > r_s2.key[3]) begin
            n_s3.key[2] = r_s2.key[3];
            n_s3.key[3] = r_s2.key[2];
        end
    end

    always_comb begin
        n_s4 = r_s3;
        if (r_s3.key[0] > r_s3.key[2]) begin
            n_s4.key[0] = r_s3.key[2];
            n_s4.key[2] = r_s3.key[0];
        end
        if (r_s3.key[1] > r_s3.key[3]) begin
            n_s4.key[1] = r_s3.key[3];
            n_s4.key[3] = r_s3.key[1];
        end
    end

    always_comb begin
        n_s5 = r_s4;
        if (r_s4.key[1] > r_s4.key[2]) begin
            n_s5.key[1] = r_s4.key[2];
            n_s5.key[2] = r_s4.key[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2       <= '0;
            r_s3       <= '0;
            r_s4       <= '0;
            r_s5       <= '0;
        end else if (adv) begin
            r_s1       <= i_head;
            r_s1_valid <= !i_empty;
            r_s2       <= n_s2;
            r_s3       <= n_s3;
            r_s4       <= n_s4;
            r_s5       <= n_s5;
        end
    end

    always_comb begin
        cnt = '0;
        for (int k = 0; k < lnq_pkg::NBR_MAX; k++) begin
            cnt = cnt + (lnq_pkg::NBR_IW+1)'(!r_s5.key[k][lnq_pkg::SITE_W]);
        end
        for (int k = 0; k < lnq_pkg::NBR_MAX; k++) begin
            n_em_res[k] = '0;
        end
        n_em_res[0].last = 1'b1;
        n_em_last        = '0;
        if (r_s5.status != lnq_pkg::ST_OK) begin
            n_em_res[0].status = r_s5.status;
        end else if (r_s5.opcode == lnq_pkg::OP_TEST) begin
            n_em_res[0].is_adjacent = r_s5.adj;
        end else if (cnt != '0) begin
            n_em_last = lnq_pkg::NBR_IW'(cnt - 1'b1);
            for (int k = 0; k < lnq_pkg::NBR_MAX; k++) begin
                n_em_res[k].neighbor_site    = r_s5.key[k][lnq_pkg::SITE_W-1:0];
                n_em_res[k].neighbor_present = 1'b1;
                n_em_res[k].last = ((lnq_pkg::NBR_IW+1)'(k) == cnt - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid  <= 1'b0;
            r_em_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_em_valid;
            if (adv) begin
                r_em_valid <= r_s5.valid;
                r_em_idx   <= '0;
            end else begin
                r_em_idx <= r_em_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_em_res[r_em_idx];
        if (adv) begin
            r_em_res  <= n_em_res;
            r_em_last <= n_em_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

// ----- test/lnq_checker.sv -----
`timescale 1ns / 1ps
// Checker for lattice_neighbor_query: follows register writes, forecasts the
// result beats of every accepted command and compares them in order.
// Depends on lnq_pkg.
module lnq_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  lnq_pkg::t_cmd             i_cmd,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [lnq_pkg::EXT_W-1:0] i_cfg_data,
    input  logic                      i_res_valid,
    input  lnq_pkg::t_result          i_res,
    output int                        o_fail_count,
    output int                        o_pending
);

    logic                      chain_mode = 1'b0;
    logic [lnq_pkg::EXT_W-1:0] width_x    = 11'd4;
    logic [lnq_pkg::EXT_W-1:0] height_y   = 11'd4;
    logic                      periodic   = 1'b0;
    lnq_pkg::t_result          beats_due[$];
    int                        fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t ns: mismatch on %s, got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void add_due(lnq_pkg::t_result r);
        beats_due.insert(beats_due.size(), r);
    endfunction

    function automatic void forecast_beats(lnq_pkg::t_cmd c);
        int unsigned      w, h, lim, total, s, col, row, v;
        int unsigned      nb[4];
        int               n, i, j;
        bit               hit;
        lnq_pkg::t_result r;
        r      = '0;
        r.last = 1'b1;
        lim    = periodic ? 3 : 1;
        w      = width_x;
        h      = chain_mode ? 1 : height_y;
        if (w < lim || w > lnq_pkg::MAX_EXTENT ||
            (!chain_mode && (height_y < lim || height_y > lnq_pkg::MAX_EXTENT))) begin
            r.status = lnq_pkg::ST_CONFIG;
            add_due(r);
            return;
        end
        total = chain_mode ? w : w * h;
        s     = c.site_a;
        if (s >= total || (c.opcode == lnq_pkg::OP_TEST && c.site_b >= total)) begin
            r.status = lnq_pkg::ST_RANGE;
            add_due(r);
            return;
        end
        col = s % w;
        row = s / w;
        n   = 0;
        if (col > 0) begin
            nb[n] = s - 1;
            n++;
        end else if (periodic) begin
            nb[n] = s + (w - 1);
            n++;
        end
        if (col + 1 < w) begin
            nb[n] = s + 1;
            n++;
        end else if (periodic) begin
            nb[n] = s - (w - 1);
            n++;
        end
        if (!chain_mode) begin
            if (row > 0) begin
                nb[n] = s - w;
                n++;
            end else if (periodic) begin
                nb[n] = s + (h - 1) * w;
                n++;
            end
            if (row + 1 < h) begin
                nb[n] = s + w;
                n++;
            end else if (periodic) begin
                nb[n] = col;
                n++;
            end
        end
        for (i = 1; i < n; i++) begin
            v = nb[i];
            j = i - 1;
            while (j >= 0 && nb[j] > v) begin
                nb[j + 1] = nb[j];
                j--;
            end
            nb[j + 1] = v;
        end
        r.status = lnq_pkg::ST_OK;
        if (c.opcode == lnq_pkg::OP_TEST) begin
            hit = 1'b0;
            for (i = 0; i < n; i++)
                if (nb[i] == c.site_b) hit = 1'b1;
            r.is_adjacent = hit;
            add_due(r);
            return;
        end
        if (n == 0) begin
            add_due(r);
            return;
        end
        for (i = 0; i < n; i++) begin
            r.neighbor_site    = nb[i][lnq_pkg::SITE_W-1:0];
            r.neighbor_present = 1'b1;
            r.last             = (i == n - 1);
            add_due(r);
        end
    endfunction

    task automatic check_beat(lnq_pkg::t_result got);
        lnq_pkg::t_result want;
        if (beats_due.size() == 0) begin
            report_mismatch("beat with nothing pending", got, 0);
            return;
        end
        want = beats_due.pop_front();
        if (got.neighbor_site !== want.neighbor_site)
            report_mismatch("neighbor_site", got.neighbor_site, want.neighbor_site);
        if (got.neighbor_present !== want.neighbor_present)
            report_mismatch("neighbor_present", got.neighbor_present, want.neighbor_present);
        if (got.is_adjacent !== want.is_adjacent)
            report_mismatch("is_adjacent", got.is_adjacent, want.is_adjacent);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chain_mode = 1'b0;
            width_x    = 11'd4;
            height_y   = 11'd4;
            periodic   = 1'b0;
            beats_due.delete();
        end else begin
            if (i_res_valid === 1'b1) check_beat(i_res);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    lnq_pkg::CFG_IS_CHAIN: chain_mode = i_cfg_data[0];
                    lnq_pkg::CFG_EXTENT_X: width_x    = i_cfg_data;
                    lnq_pkg::CFG_EXTENT_Y: height_y   = i_cfg_data;
                    lnq_pkg::CFG_WRAP:     periodic   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) forecast_beats(i_cmd);
        end
        o_pending <= beats_due.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for lattice_neighbor_query: drives register writes and query
// commands and gives the verdict from the checker's failure and pending counts.
// Depends on lnq_pkg, lattice_neighbor_query and lnq_checker.
module tb;

    localparam int ITEM_COUNT  = 470;
    localparam int HOLD_CYCLES = 40;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      start     = 1'b0;
    lnq_pkg::t_cmd             cmd       = '0;
    logic                      cfg_valid = 1'b0;
    logic [1:0]                cfg_index = lnq_pkg::CFG_IS_CHAIN;
    logic [lnq_pkg::EXT_W-1:0] cfg_data  = '0;
    logic                      busy;
    logic                      cfg_ready;
    logic                      res_valid;
    lnq_pkg::t_result          res;
    int                        fail_count;
    int                        pending;

    logic        lat_chain = 1'b0;
    int unsigned lat_w     = 4;
    int unsigned lat_h     = 4;
    int          sent      = 0;
    bit          steady    = 1'b0;

    lattice_neighbor_query u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (cmd),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    lnq_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (cmd),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_res_valid  (res_valid),
        .i_res        (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic lnq_pkg::t_cmd make_cmd(logic op, int unsigned a, int unsigned b);
        lnq_pkg::t_cmd c;
        c.opcode = op;
        c.site_a = a[lnq_pkg::SITE_W-1:0];
        c.site_b = b[lnq_pkg::SITE_W-1:0];
        return c;
    endfunction

    function automatic int unsigned lattice_sites();
        if (lat_w < 1 || lat_w > lnq_pkg::MAX_EXTENT) return 0;
        if (!lat_chain && (lat_h < 1 || lat_h > lnq_pkg::MAX_EXTENT)) return 0;
        return lat_chain ? lat_w : lat_w * lat_h;
    endfunction

    function automatic int unsigned pick_site_a();
        int unsigned total, p;
        total = lattice_sites();
        p     = $urandom_range(0, 99);
        if (total == 0 || p >= 88) return $urandom() & 32'hFFFFF;
        if (p < 74) return $urandom_range(0, total - 1);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return total - 1;
            2:       return lat_w - 1;
            3:       return total - lat_w;
            default: return total & 32'hFFFFF;
        endcase
    endfunction

    function automatic int unsigned pick_site_b(int unsigned a);
        int unsigned total, h, off;
        total = lattice_sites();
        h     = lat_chain ? 1 : lat_h;
        if (total == 0 || a >= total || $urandom_range(0, 99) >= 90)
            return $urandom() & 32'hFFFFF;
        case ($urandom_range(0, 9))
            0:       off = 0;
            1:       off = 1;
            2:       off = total - 1;
            3:       off = lat_w;
            4:       off = total - lat_w;
            5:       off = lat_w - 1;
            6:       off = total - (lat_w - 1);
            7:       off = (h - 1) * lat_w;
            8:       off = total - (h - 1) * lat_w;
            default: return $urandom_range(0, total - 1);
        endcase
        return (a + off) % total;
    endfunction

    task automatic issue(lnq_pkg::t_cmd c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
        if (!steady) begin
            while ($urandom_range(0, 99) < 26) begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_lattice(logic chain, int unsigned x, int unsigned y, logic wrap);
        lnq_pkg::t_cfg_reg         order[4];
        logic [lnq_pkg::EXT_W-1:0] vals[4];
        int                        k;
        order[0] = lnq_pkg::CFG_IS_CHAIN;
        order[1] = lnq_pkg::CFG_EXTENT_X;
        order[2] = lnq_pkg::CFG_EXTENT_Y;
        order[3] = lnq_pkg::CFG_WRAP;
        vals[0]  = {10'($urandom()), chain};
        vals[1]  = lnq_pkg::EXT_W'(x);
        vals[2]  = lnq_pkg::EXT_W'(y);
        vals[3]  = {10'($urandom()), wrap};
        drain();
        cfg_valid <= 1'b1;
        for (k = 0; k < 4; k++) begin
            cfg_index <= order[k];
            cfg_data  <= vals[k];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
        end
        cfg_valid <= 1'b0;
        lat_chain = chain;
        lat_w     = x;
        lat_h     = y;
    endtask

    task automatic random_lattice();
        int unsigned p, x, y;
        logic        chain, wrap;
        p     = $urandom_range(0, 99);
        chain = $urandom_range(0, 1);
        wrap  = $urandom_range(0, 1);
        x     = $urandom_range(1, 9);
        y     = $urandom_range(1, 9);
        if (p >= 70 && p < 80) begin
            x = $urandom_range(10, lnq_pkg::MAX_EXTENT);
        end else if (p >= 80 && p < 88) begin
            y = $urandom_range(10, lnq_pkg::MAX_EXTENT);
        end else if (p >= 88 && p < 93) begin
            x = lnq_pkg::MAX_EXTENT;
            y = lnq_pkg::MAX_EXTENT;
        end else if (p >= 93) begin
            x = $urandom_range(0, 1) ? 0 : $urandom_range(lnq_pkg::MAX_EXTENT + 1, 2047);
        end
        if (chain && $urandom_range(0, 1)) y = $urandom_range(0, 2047);
        set_lattice(chain, x, y, wrap);
    endtask

    initial begin
        int          n, k;
        int unsigned a;
        logic        op;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Lattice after reset: 4 by 4, open edges.
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 20'hFFFFF));
        issue(make_cmd(lnq_pkg::OP_LIST, 5, 0));
        issue(make_cmd(lnq_pkg::OP_LIST, 15, 0));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 1));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 4));
        issue(make_cmd(lnq_pkg::OP_TEST, 5, 5));
        issue(make_cmd(lnq_pkg::OP_TEST, 3, 4));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 5));
        issue(make_cmd(lnq_pkg::OP_LIST, 16, 0));
        issue(make_cmd(lnq_pkg::OP_LIST, 20'hFFFFF, 0));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 16));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 20'hFFFFF));

        set_lattice(1'b1, 3, 0, 1'b1);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 2));
        set_lattice(1'b0, lnq_pkg::MAX_EXTENT, lnq_pkg::MAX_EXTENT, 1'b1);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        issue(make_cmd(lnq_pkg::OP_LIST, 20'hFFFFF, 0));
        issue(make_cmd(lnq_pkg::OP_TEST, 20'hFFFFF, 20'hFFC00));
        set_lattice(1'b1, 1, 7, 1'b0);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        set_lattice(1'b0, 1, 1, 1'b0);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        issue(make_cmd(lnq_pkg::OP_TEST, 0, 0));
        set_lattice(1'b0, 2, 5, 1'b1);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        set_lattice(1'b0, lnq_pkg::MAX_EXTENT + 1, 4, 1'b0);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));
        set_lattice(1'b0, 4, 0, 1'b0);
        issue(make_cmd(lnq_pkg::OP_LIST, 0, 0));

        while (sent < ITEM_COUNT) begin
            random_lattice();
            n = $urandom_range(8, 30);
            for (k = 0; k < n; k++) begin
                steady = (sent >= 200 && sent < 290);
                if ($urandom_range(0, 39) == 0) drain();
                op = $urandom_range(0, 1) ? lnq_pkg::OP_TEST : lnq_pkg::OP_LIST;
                a  = pick_site_a();
                issue(make_cmd(op, a, pick_site_b(a)));
            end
        end

        drain();
        repeat (HOLD_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
